[rtl/led_pkg.sv]
// ----------------------------------------------------------------------------
// Line editor package
// Shared sizes, event and command codes, escape parser phases, sequencer
// states, the memory request type and address helpers used by the line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package led_pkg;

  localparam int LINE_CHARS    = 128;
  localparam int HISTORY_DEPTH = 8;
  localparam int CW            = $clog2(LINE_CHARS);
  localparam int HW            = $clog2(HISTORY_DEPTH);
  localparam int LINE_AW       = CW + 1;
  localparam int HIST_AW       = HW + CW;

  // Memory map of the one shared character memory: line, then draft, then ring.
  localparam int MEM_WORDS = 2 * LINE_CHARS + HISTORY_DEPTH * LINE_CHARS;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  typedef logic [CW-1:0] char_idx_t;
  typedef logic [6:0]    chr_t;

  typedef enum logic [3:0] {
    EV_NONE = 4'd0, EV_INSERT = 4'd1, EV_BKSP = 4'd2, EV_DELETE = 4'd3,
    EV_LEFT = 4'd4, EV_RIGHT = 4'd5, EV_RECALL = 4'd6, EV_DRAFT = 4'd7,
    EV_COMMIT = 4'd8, EV_READ = 4'd9
  } event_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0, PH_ESC = 2'd1, PH_CSI = 2'd2, PH_CSI3 = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_FEED = 2'd0, CMD_READ_LINE = 2'd1, CMD_READ_HIST = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SHIFT_RD, ST_SHIFT_WR, ST_COPY_RD, ST_COPY_WR,
    ST_CMP_RD, ST_CMP_CHK, ST_READ_RD, ST_READ_WAIT, ST_DONE
  } state_t;

  // Memory request from the sequencer to the store.
  typedef struct packed {
    logic                 we;
    logic [MEM_AW-1:0]    waddr;
    chr_t                 wdata;
    logic [MEM_AW-1:0]    raddr;
  } mem_req_t;

  function automatic logic [MEM_AW-1:0] line_addr(input char_idx_t i);
    return MEM_AW'(i);
  endfunction

  function automatic logic [MEM_AW-1:0] draft_addr(input char_idx_t i);
    return MEM_AW'(LINE_CHARS) + MEM_AW'(i);
  endfunction

  function automatic logic [MEM_AW-1:0] hist_addr(input logic [HW-1:0] s,
                                                   input char_idx_t i);
    return MEM_AW'(2 * LINE_CHARS) + MEM_AW'({s, i});
  endfunction

endpackage

`default_nettype wire

[rtl/led_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module led_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/led_store.sv]
// ----------------------------------------------------------------------------
// Character store
// Holds line, draft and history characters in one RAM, and the entry
// lengths in a second small RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module led_store (
  input  wire logic                         clk,
  input  wire led_pkg::mem_req_t            req,
  output led_pkg::chr_t                     rdata,
  input  wire logic                         len_we,
  input  wire logic [led_pkg::HW-1:0]       len_waddr,
  input  wire led_pkg::chr_t                len_wdata,
  input  wire logic [led_pkg::HW-1:0]       len_raddr,
  output led_pkg::chr_t                     len_rdata
);
  import led_pkg::*;

  // Character memory.
  led_ram #(.WIDTH(7), .DEPTH(MEM_WORDS)) u_chars (
    .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wdata),
    .raddr(req.raddr), .rdata(rdata)
  );

  // History length memory.
  led_ram #(.WIDTH(7), .DEPTH(HISTORY_DEPTH)) u_lens (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

endmodule

`default_nettype wire

[rtl/line_editor_with_history.sv]
// ----------------------------------------------------------------------------
// Line editor with history
// Edits one terminal line and keeps a ring of committed lines.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. The input stays stalled while a result
// waits, and the next transaction can be accepted in the cycle after the
// result is taken. Cursor moves, escape bytes, ignored bytes and line reads
// past the end go straight to the done state; other reads first wait for
// the registered read data. Insert, backspace and delete shift the tail of
// the line one character at a time, with a read and a write state for each.
// History recall, draft save and restore and commit copy one character at a
// time in the same way, and the duplicate check on commit reads the line and
// the ring character and then compares them. The worst case is a commit of a
// full line that differs from the newest entry only in its last character.
// All characters live in one RAM with one read and one write port.
`default_nettype none

module line_editor_with_history (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_in_byte,
  input  wire logic [6:0] in_char_index,
  input  wire logic [2:0] in_entry_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_event_res,
  output logic [6:0]      out_cursor,
  output logic [6:0]      out_line_length,
  output logic [3:0]      out_entry_count,
  output logic [6:0]      out_read_char,
  output logic [6:0]      out_read_length,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_history_limit
);
  import led_pkg::*;

  state_t   st_r, st_nxt;
  phase_t   ph_r, ph_nxt;
  chr_t     len_r, len_nxt, cur_r, cur_nxt, dlen_r, dlen_nxt;
  logic     dval_r, dval_nxt, brw_r, brw_nxt;
  logic [HW:0]   used_r, used_nxt, bpos_r, bpos_nxt;
  logic [HW-1:0] next_r, next_nxt;
  logic [3:0]    cap_r, cap_nxt;
  event_t   ev_r, ev_nxt;
  chr_t     slen_r, slen_nxt, rch_r, rch_nxt, rlen_r, rlen_nxt;
  logic     ov_r, ov_nxt;

  // Sequencer working registers for shifts, copies and compares.
  chr_t          i_r, i_nxt, end_r, end_nxt, tmp_r, tmp_nxt;
  logic          dir_r, dir_nxt;            // shift: 1 insert (move up)
  logic [1:0]    csrc_r, csrc_nxt, cdst_r, cdst_nxt; // 0 line 1 draft 2 ring
  logic [HW-1:0] slot_r, slot_nxt;
  logic          cpost_r, cpost_nxt;        // copy is a commit: ring update at end
  logic          cphase_r, cphase_nxt;      // compare: second read
  chr_t          ins_r, ins_nxt;

  mem_req_t      req;
  chr_t          rdata, lrdata;
  logic          len_we;
  logic [HW-1:0] len_waddr, len_raddr;
  chr_t          len_wdata;

  led_store u_store (
    .clk(clk), .req(req), .rdata(rdata), .len_we(len_we), .len_waddr(len_waddr),
    .len_wdata(len_wdata), .len_raddr(len_raddr), .len_rdata(lrdata)
  );

  localparam logic [1:0] R_LINE = 2'd0, R_DRAFT = 2'd1, R_RING = 2'd2;

  function automatic logic [MEM_AW-1:0] ra(input logic [1:0] r,
      input logic [HW-1:0] s, input chr_t i);
    case (r)
      R_LINE:  return line_addr(i);
      R_DRAFT: return draft_addr(i);
      default: return hist_addr(s, i);
    endcase
  endfunction

  // Slot of an age: (next + cap - used + age) mod cap, all below 2*cap.
  function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] nx,
      input logic [HW:0] us, input logic [HW:0] age, input logic [3:0] cap);
    logic [HW+2:0] t;
    t = (HW+3)'(nx) + (HW+3)'(cap) - (HW+3)'(us) + (HW+3)'(age);
    if (t >= (HW+3)'(cap)) t = t - (HW+3)'(cap);
    return HW'(t);
  endfunction

  // A pending register write holds off the input so that both never meet.
  logic in_acc;
  assign in_stall  = (st_r != ST_IDLE) || ov_r || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (st_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_event_res   = ev_r;
  assign out_cursor      = cur_r;
  assign out_line_length = slen_r;
  assign out_entry_count = 4'(used_r);
  assign out_read_char   = rch_r;
  assign out_read_length = rlen_r;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_NORMAL; len_r <= '0; cur_r <= '0;
      dlen_r <= '0; dval_r <= 1'b0; brw_r <= 1'b0; used_r <= '0; bpos_r <= '0;
      next_r <= '0; cap_r <= 4'(HISTORY_DEPTH); ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; len_r <= len_nxt; cur_r <= cur_nxt;
      dlen_r <= dlen_nxt; dval_r <= dval_nxt; brw_r <= brw_nxt;
      used_r <= used_nxt; bpos_r <= bpos_nxt; next_r <= next_nxt;
      cap_r <= cap_nxt; ov_r <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ev_r <= ev_nxt; slen_r <= slen_nxt; rch_r <= rch_nxt; rlen_r <= rlen_nxt;
    i_r <= i_nxt; end_r <= end_nxt; tmp_r <= tmp_nxt; dir_r <= dir_nxt;
    csrc_r <= csrc_nxt; cdst_r <= cdst_nxt; slot_r <= slot_nxt;
    cpost_r <= cpost_nxt; cphase_r <= cphase_nxt; ins_r <= ins_nxt;
  end

  // Sequencer.
  always_comb begin
    logic [HW-1:0] ls;
    logic [7:0]    c;
    st_nxt = st_r; ph_nxt = ph_r; len_nxt = len_r; cur_nxt = cur_r;
    dlen_nxt = dlen_r; dval_nxt = dval_r; brw_nxt = brw_r; used_nxt = used_r;
    bpos_nxt = bpos_r; next_nxt = next_r; cap_nxt = cap_r; ov_nxt = ov_r;
    ev_nxt = ev_r; slen_nxt = slen_r; rch_nxt = rch_r; rlen_nxt = rlen_r;
    i_nxt = i_r; end_nxt = end_r; tmp_nxt = tmp_r; dir_nxt = dir_r;
    csrc_nxt = csrc_r; cdst_nxt = cdst_r; slot_nxt = slot_r; cpost_nxt = cpost_r;
    cphase_nxt = cphase_r; ins_nxt = ins_r;
    req = '0; len_we = 1'b0; len_waddr = next_r; len_wdata = len_r;
    len_raddr = slot_r;
    ls = '0;
    c = in_in_byte;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          if (cfg_history_limit == 4'd0) cap_nxt = 4'd1;
          else if (cfg_history_limit > 4'(HISTORY_DEPTH)) cap_nxt = 4'(HISTORY_DEPTH);
          else cap_nxt = cfg_history_limit;
          used_nxt = '0; next_nxt = '0; brw_nxt = 1'b0; bpos_nxt = '0;
        end else if (in_acc) begin
          ev_nxt = EV_NONE; rch_nxt = '0; rlen_nxt = '0;
          st_nxt = ST_DONE;
          case (cmd_t'(in_cmd))
            CMD_FEED: begin
              case (ph_r)
                PH_NORMAL: begin
                  if (c == 8'h1b) ph_nxt = PH_ESC;
                  else if (c == 8'h0d || c == 8'h0a) begin
                    ev_nxt = EV_COMMIT;
                    if (len_r != '0 && used_r != '0) begin
                      // Check the newest entry for a duplicate first.
                      ls = (next_r == '0) ? HW'(cap_r - 4'd1) : next_r - 1'b1;
                      slot_nxt = ls; len_raddr = ls; i_nxt = '0;
                      cphase_nxt = 1'b0; st_nxt = ST_CMP_RD;
                    end else if (len_r != '0) begin
                      csrc_nxt = R_LINE; cdst_nxt = R_RING; slot_nxt = next_r;
                      i_nxt = '0; end_nxt = len_r; cpost_nxt = 1'b1;
                      st_nxt = ST_COPY_RD;
                    end else begin
                      st_nxt = ST_DONE; slen_nxt = '0;
                      brw_nxt = 1'b0; dval_nxt = 1'b0;
                    end
                  end else if (c == 8'h08 || c == 8'h7f) begin
                    if (cur_r != '0) begin
                      ev_nxt = EV_BKSP; dir_nxt = 1'b0; i_nxt = cur_r;
                      end_nxt = len_r; st_nxt = ST_SHIFT_RD;
                      cur_nxt = cur_r - 1'b1; len_nxt = len_r - 1'b1;
                    end
                  end else if (c >= 8'h20 && c < 8'h7f) begin
                    if (32'(len_r) < LINE_CHARS - 1) begin
                      ev_nxt = EV_INSERT; dir_nxt = 1'b1; ins_nxt = c[6:0];
                      i_nxt = len_r; end_nxt = cur_r; st_nxt = ST_SHIFT_RD;
                      cur_nxt = cur_r + 1'b1; len_nxt = len_r + 1'b1;
                    end
                  end
                end
                PH_ESC: ph_nxt = (c == 8'h5b) ? PH_CSI : PH_NORMAL;
                PH_CSI: begin
                  ph_nxt = PH_NORMAL;
                  if (c == 8'h41) begin
                    if (used_r != '0 && !brw_r) begin
                      ev_nxt = EV_RECALL; brw_nxt = 1'b1; dval_nxt = 1'b1;
                      dlen_nxt = len_r; bpos_nxt = used_r - 1'b1;
                      csrc_nxt = R_LINE; cdst_nxt = R_DRAFT; i_nxt = '0;
                      end_nxt = len_r; cpost_nxt = 1'b0; st_nxt = ST_COPY_RD;
                      // After the draft copy the entry is loaded.
                      cphase_nxt = 1'b1;
                    end else if (used_r != '0 && bpos_r != '0) begin
                      ev_nxt = EV_RECALL; bpos_nxt = bpos_r - 1'b1;
                      ls = slot_of(next_r, used_r, bpos_r - 1'b1, cap_r);
                      slot_nxt = ls; len_raddr = ls; cphase_nxt = 1'b0;
                      st_nxt = ST_READ_RD; csrc_nxt = R_RING;
                    end
                  end else if (c == 8'h42) begin
                    if (brw_r && (bpos_r + 1'b1) < used_r) begin
                      ev_nxt = EV_RECALL; bpos_nxt = bpos_r + 1'b1;
                      ls = slot_of(next_r, used_r, bpos_r + 1'b1, cap_r);
                      slot_nxt = ls; len_raddr = ls; cphase_nxt = 1'b0;
                      st_nxt = ST_READ_RD; csrc_nxt = R_RING;
                    end else if (brw_r) begin
                      ev_nxt = EV_DRAFT; brw_nxt = 1'b0;
                      if (dval_r) begin
                        dval_nxt = 1'b0; len_nxt = dlen_r; cur_nxt = dlen_r;
                        csrc_nxt = R_DRAFT; cdst_nxt = R_LINE; i_nxt = '0;
                        end_nxt = dlen_r; cpost_nxt = 1'b0; cphase_nxt = 1'b0;
                        st_nxt = ST_COPY_RD;
                      end else begin
                        len_nxt = '0; cur_nxt = '0;
                      end
                    end
                  end else if (c == 8'h43) begin
                    if (cur_r < len_r) begin
                      ev_nxt = EV_RIGHT; cur_nxt = cur_r + 1'b1;
                    end
                  end else if (c == 8'h44) begin
                    if (cur_r != '0) begin
                      ev_nxt = EV_LEFT; cur_nxt = cur_r - 1'b1;
                    end
                  end else if (c == 8'h33) ph_nxt = PH_CSI3;
                end
                default: begin
                  ph_nxt = PH_NORMAL;
                  if (c == 8'h7e && cur_r < len_r) begin
                    ev_nxt = EV_DELETE; dir_nxt = 1'b0; i_nxt = cur_r + 1'b1;
                    end_nxt = len_r; len_nxt = len_r - 1'b1;
                    st_nxt = ST_SHIFT_RD;
                  end
                end
              endcase
            end
            CMD_READ_LINE: begin
              ev_nxt = EV_READ; rlen_nxt = len_r;
              if (in_char_index < len_r) begin
                req.raddr = line_addr(in_char_index); st_nxt = ST_READ_WAIT;
                csrc_nxt = R_LINE;
              end
            end
            CMD_READ_HIST: begin
              ev_nxt = EV_READ;
              if ((HW+1)'(in_entry_index) < used_r) begin
                ls = slot_of(next_r, used_r, (HW+1)'(in_entry_index), cap_r);
                slot_nxt = ls; len_raddr = ls; i_nxt = in_char_index;
                cphase_nxt = 1'b1; csrc_nxt = R_RING; st_nxt = ST_READ_RD;
                req.raddr = hist_addr(ls, in_char_index);
              end
            end
            default: ;
          endcase
        end
      end

      // Shift one character: insert walks down from the end, delete walks up.
      ST_SHIFT_RD: begin
        if (dir_r) begin
          if (i_r == end_r) begin
            req.we = 1'b1; req.waddr = line_addr(end_r); req.wdata = ins_r;
            st_nxt = ST_DONE;
          end else begin
            req.raddr = line_addr(i_r - 1'b1); st_nxt = ST_SHIFT_WR;
          end
        end else begin
          if (i_r >= end_r) st_nxt = ST_DONE;
          else begin
            req.raddr = line_addr(i_r); st_nxt = ST_SHIFT_WR;
          end
        end
      end
      ST_SHIFT_WR: begin
        req.we = 1'b1; req.wdata = rdata;
        if (dir_r) begin
          req.waddr = line_addr(i_r); i_nxt = i_r - 1'b1;
        end else begin
          req.waddr = line_addr(i_r - 1'b1); i_nxt = i_r + 1'b1;
        end
        st_nxt = ST_SHIFT_RD;
      end

      // Block copy between regions.
      ST_COPY_RD: begin
        if (i_r == end_r) begin
          if (cpost_r) begin
            len_we = 1'b1; len_waddr = next_r; len_wdata = len_r;
            next_nxt = (4'(next_r) + 4'd1 >= cap_r) ? '0 : next_r + 1'b1;
            if (4'(used_r) < cap_r) used_nxt = used_r + 1'b1;
            cpost_nxt = 1'b0;
            st_nxt = ST_DONE; slen_nxt = len_r; len_nxt = '0; cur_nxt = '0;
            brw_nxt = 1'b0; dval_nxt = 1'b0;
          end else if (cphase_r) begin
            // Draft saved: now load the newest entry.
            ls = slot_of(next_r, used_r, bpos_r, cap_r);
            slot_nxt = ls; len_raddr = ls; cphase_nxt = 1'b0;
            st_nxt = ST_READ_RD;
          end else st_nxt = ST_DONE;
        end else begin
          req.raddr = ra(csrc_r, slot_r, i_r); st_nxt = ST_COPY_WR;
        end
      end
      ST_COPY_WR: begin
        req.we = 1'b1; req.waddr = ra(cdst_r, slot_r, i_r); req.wdata = rdata;
        i_nxt = i_r + 1'b1; st_nxt = ST_COPY_RD;
      end

      // Duplicate check against the newest entry.
      ST_CMP_RD: begin
        if (!cphase_r) begin
          // First pass: length of the newest entry is now on lrdata.
          if (lrdata != len_r || i_r == len_r) begin
            if (lrdata == len_r) begin
              st_nxt = ST_DONE; slen_nxt = len_r; len_nxt = '0; cur_nxt = '0;
              brw_nxt = 1'b0; dval_nxt = 1'b0;
            end else begin
              csrc_nxt = R_LINE; cdst_nxt = R_RING; slot_nxt = next_r;
              i_nxt = '0; end_nxt = len_r; cpost_nxt = 1'b1; cphase_nxt = 1'b0;
              st_nxt = ST_COPY_RD;
            end
          end else begin
            req.raddr = line_addr(i_r); cphase_nxt = 1'b1;
          end
        end else begin
          tmp_nxt = rdata; req.raddr = hist_addr(slot_r, i_r);
          st_nxt = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        if (rdata != tmp_r) begin
          csrc_nxt = R_LINE; cdst_nxt = R_RING; slot_nxt = next_r;
          i_nxt = '0; end_nxt = len_r; cpost_nxt = 1'b1; cphase_nxt = 1'b0;
          st_nxt = ST_COPY_RD;
        end else begin
          i_nxt = i_r + 1'b1; cphase_nxt = 1'b0; st_nxt = ST_CMP_RD;
          len_raddr = slot_r;
        end
      end

      // Length read of a ring slot, then a recall copy or a history read.
      ST_READ_RD: begin
        if (cphase_r) begin
          rlen_nxt = lrdata;
          rch_nxt = (i_r < lrdata) ? rdata : '0;
          st_nxt = ST_DONE;
        end else begin
          len_nxt = lrdata; cur_nxt = lrdata;
          csrc_nxt = R_RING; cdst_nxt = R_LINE; i_nxt = '0; end_nxt = lrdata;
          cpost_nxt = 1'b0; st_nxt = ST_COPY_RD;
        end
      end
      ST_READ_WAIT: begin
        rch_nxt = rdata; st_nxt = ST_DONE;
      end

      default: begin
        if (ev_r != EV_COMMIT) slen_nxt = len_r;
        ov_nxt = 1'b1; st_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
